>>> rtl/rtc_prescaled_counter_compare_defines.svh
// Assertion macros used by the checker file.
`ifndef RTC_PRESCALED_COUNTER_COMPARE_DEFINES_SVH
`define RTC_PRESCALED_COUNTER_COMPARE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RPCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RPCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rpcc_pkg.sv
package rpcc_pkg;

    // Widths of the request and response fields
    localparam int OP_W    = 2;
    localparam int OFF_W   = 12;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 24;
    localparam int PRESC_W = 12;

    localparam int NUM_COMPARE_DEF = 4;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [OFF_W-1:0]   offset_t;
    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [PRESC_W-1:0] presc_t;

    // Request operations
    localparam op_t OP_READ  = 2'd0;
    localparam op_t OP_WRITE = 2'd1;
    localparam op_t OP_TICK  = 2'd2;

    // Register map (byte offsets)
    localparam offset_t OFF_START     = 12'h000;
    localparam offset_t OFF_STOP      = 12'h004;
    localparam offset_t OFF_CLEAR     = 12'h008;
    localparam offset_t OFF_TRIG_OVF  = 12'h00C;
    localparam offset_t OFF_EVT_TICK  = 12'h100;
    localparam offset_t OFF_EVT_OVF   = 12'h104;
    localparam offset_t OFF_EVT_CMP   = 12'h140;
    localparam offset_t OFF_INTEN_SET = 12'h304;
    localparam offset_t OFF_INTEN_CLR = 12'h308;
    localparam offset_t OFF_EVTEN_SET = 12'h340;
    localparam offset_t OFF_EVTEN_CLR = 12'h344;
    localparam offset_t OFF_COUNTER   = 12'h504;
    localparam offset_t OFF_PRESC     = 12'h508;
    localparam offset_t OFF_CC        = 12'h540;

    // Task trigger value
    localparam data_t TASK_TRIGGER = 32'd1;

    // Counter preset for the overflow task
    localparam count_t OVF_PRESET = 24'hFFFFF0;

    // Interrupt enable bit positions
    localparam int INT_TICK_BIT = 0;
    localparam int INT_OVF_BIT  = 1;
    localparam int INT_CMP_BASE = 16;

endpackage

>>> rtl/rpcc_req_if.sv
interface rpcc_req_if;
    import rpcc_pkg::*;

    logic    valid;
    logic    ready;
    op_t     operation;
    offset_t offset;
    data_t   write_data;

    modport source (output valid, output operation, output offset, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input offset, input write_data,
                    output ready);
endinterface

>>> rtl/rpcc_rsp_if.sv
interface rpcc_rsp_if;
    import rpcc_pkg::*;

    logic  valid;
    logic  ready;
    data_t read_data;
    logic  irq_raise;

    modport source (output valid, output read_data, output irq_raise, input ready);
    modport sink   (input valid, input read_data, input irq_raise, output ready);
endinterface

>>> rtl/rtc_prescaled_counter_compare.sv
// Real-time counter with 12-bit prescaler, 24-bit counter and compare events.
// Channel req carries one request: a bus read, a bus write (offset, write_data)
// or one low-frequency clock tick. Channel rsp returns exactly one response per
// request, in order: read_data (zero unless a read of a mapped register) and
// irq_raise (one when a tick bumps the counter with an enabled event latched).
// A request is taken into an input register, processed by one pass of logic
// into the response register, and the register state is updated at that edge.
// A request accepted into the input register moves on to the response register,
// from which rsp offers its response.
// Throughput: one request per cycle while rsp is not stalled, set by the single
// register update per request in the state registers.
// If rsp is stalled, the response register holds, the input register keeps
// one more request, and req.ready drops only while both are full.
// Reset clears the counter, prescaler, compare values, events and enables and
// leaves the counter stopped; both pipeline registers come out of reset empty.
module rtc_prescaled_counter_compare #(
    parameter int NUM_COMPARE = rpcc_pkg::NUM_COMPARE_DEF
) (
    input logic        clk,
    input logic        rst_n,
    rpcc_req_if.sink   req,
    rpcc_rsp_if.source rsp
);
    import rpcc_pkg::*;

    // Input register
    logic    s1_valid_reg;
    op_t     op_reg;
    offset_t off_reg;
    data_t   wdata_reg;

    // Response register
    logic    rsp_valid_reg;
    data_t   rd_reg;
    logic    irq_reg;

    // Architectural state
    logic                   running_reg,  running_next;
    count_t                 count_reg,    count_next;
    presc_t                 presc_reg,    presc_next;
    presc_t                 phase_reg,    phase_next;
    count_t                 cmp_val_reg  [NUM_COMPARE];
    count_t                 cmp_val_next [NUM_COMPARE];
    logic                   tick_evt_reg, tick_evt_next;
    logic                   ovf_evt_reg,  ovf_evt_next;
    logic [NUM_COMPARE-1:0] cmp_evt_reg,  cmp_evt_next;
    data_t                  int_en_reg,   int_en_next;
    data_t                  evt_en_reg,   evt_en_next;

    data_t rd_next;
    logic  irq_next;
    logic  adv;

    // Handshake: the input register moves on when the response slot frees
    assign adv       = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || adv;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.read_data = rd_reg;
    assign rsp.irq_raise = irq_reg;

    // Request processing
    always_comb
    begin
        running_next  = running_reg;
        count_next    = count_reg;
        presc_next    = presc_reg;
        phase_next    = phase_reg;
        cmp_val_next  = cmp_val_reg;
        tick_evt_next = tick_evt_reg;
        ovf_evt_next  = ovf_evt_reg;
        cmp_evt_next  = cmp_evt_reg;
        int_en_next   = int_en_reg;
        evt_en_next   = evt_en_reg;
        rd_next       = '0;
        irq_next      = 1'b0;

        case (op_reg)
            OP_READ:
            begin
                case (off_reg)
                    OFF_EVT_TICK:  rd_next = DATA_W'(tick_evt_reg);
                    OFF_EVT_OVF:   rd_next = DATA_W'(ovf_evt_reg);
                    OFF_INTEN_SET,
                    OFF_INTEN_CLR: rd_next = int_en_reg;
                    OFF_EVTEN_SET,
                    OFF_EVTEN_CLR: rd_next = evt_en_reg;
                    OFF_COUNTER:   rd_next = DATA_W'(count_reg);
                    OFF_PRESC:     rd_next = DATA_W'(presc_reg);
                    default: ;
                endcase
                // compare banks never overlap the single registers
                for (int i = 0; i < NUM_COMPARE; i++)
                begin
                    if (off_reg == OFF_EVT_CMP + OFF_W'(4 * i))
                        rd_next = DATA_W'(cmp_evt_reg[i]);
                    if (off_reg == OFF_CC + OFF_W'(4 * i))
                        rd_next = DATA_W'(cmp_val_reg[i]);
                end
            end
            OP_WRITE:
            begin
                case (off_reg)
                    OFF_START:
                        if (wdata_reg == TASK_TRIGGER && !running_reg)
                        begin
                            running_next = 1'b1;
                            phase_next   = presc_reg;
                        end
                    OFF_STOP:
                        if (wdata_reg == TASK_TRIGGER)
                            running_next = 1'b0;
                    OFF_CLEAR:
                        if (wdata_reg == TASK_TRIGGER)
                            count_next = '0;
                    OFF_TRIG_OVF:
                        if (wdata_reg == TASK_TRIGGER)
                            count_next = OVF_PRESET;
                    OFF_EVT_TICK:  tick_evt_next = wdata_reg[0];
                    OFF_EVT_OVF:   ovf_evt_next  = wdata_reg[0];
                    OFF_INTEN_SET: int_en_next   = int_en_reg | wdata_reg;
                    OFF_INTEN_CLR: int_en_next   = int_en_reg & ~wdata_reg;
                    OFF_EVTEN_SET: evt_en_next   = evt_en_reg | wdata_reg;
                    OFF_EVTEN_CLR: evt_en_next   = evt_en_reg & ~wdata_reg;
                    OFF_PRESC:     presc_next    = wdata_reg[PRESC_W-1:0];
                    default: ;
                endcase
                for (int i = 0; i < NUM_COMPARE; i++)
                begin
                    if (off_reg == OFF_EVT_CMP + OFF_W'(4 * i))
                        cmp_evt_next[i] = wdata_reg[0];
                    if (off_reg == OFF_CC + OFF_W'(4 * i))
                        cmp_val_next[i] = wdata_reg[CNT_W-1:0];
                end
            end
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (phase_reg != '0)
                        phase_next = phase_reg - 1'b1;
                    else
                    begin
                        // counter increment: latch events, evaluate interrupt
                        phase_next    = presc_reg;
                        count_next    = count_reg + 1'b1;
                        tick_evt_next = 1'b1;
                        if (count_next == '0)
                            ovf_evt_next = 1'b1;
                        for (int i = 0; i < NUM_COMPARE; i++)
                            if (cmp_val_reg[i] == count_next)
                                cmp_evt_next[i] = 1'b1;
                        irq_next = (int_en_reg[INT_TICK_BIT] && tick_evt_next) ||
                                   (int_en_reg[INT_OVF_BIT] && ovf_evt_next);
                        for (int i = 0; i < NUM_COMPARE; i++)
                            if (int_en_reg[INT_CMP_BASE + i] && cmp_evt_next[i])
                                irq_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.operation;
            off_reg   <= req.offset;
            wdata_reg <= req.write_data;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            count_reg    <= '0;
            presc_reg    <= '0;
            phase_reg    <= '0;
            tick_evt_reg <= 1'b0;
            ovf_evt_reg  <= 1'b0;
            cmp_evt_reg  <= '0;
            int_en_reg   <= '0;
            evt_en_reg   <= '0;
            for (int i = 0; i < NUM_COMPARE; i++)
                cmp_val_reg[i] <= '0;
        end
        else if (adv)
        begin
            running_reg  <= running_next;
            count_reg    <= count_next;
            presc_reg    <= presc_next;
            phase_reg    <= phase_next;
            tick_evt_reg <= tick_evt_next;
            ovf_evt_reg  <= ovf_evt_next;
            cmp_evt_reg  <= cmp_evt_next;
            int_en_reg   <= int_en_next;
            evt_en_reg   <= evt_en_next;
            cmp_val_reg  <= cmp_val_next;
        end
    end

endmodule

>>> rtl/rpcc_checker.sv
`include "rtc_prescaled_counter_compare_defines.svh"

module rpcc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input rpcc_pkg::data_t      rsp_read_data,
    input logic                 rsp_irq_raise
);
    import rpcc_pkg::*;

    // A pending response stays offered
    `RPCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

    // A stalled response keeps its payload
    `RPCC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_irq_raise), "stalled response changed")

    // Interrupt only comes from a tick, which never returns read data
    `RPCC_ASSERT_NOW(a_irq_no_data, rsp_valid && rsp_irq_raise, rsp_read_data == '0, "interrupt with read data")

    // Requests are held off only while the response slot is stalled
    `RPCC_ASSERT_NOW(a_ready_backpressure, !req_ready, rsp_valid && !rsp_ready, "request stalled without back-pressure")

endmodule

bind rtc_prescaled_counter_compare rpcc_checker u_rpcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_irq_raise (rsp.irq_raise)
);

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpcc_pkg::*;

    localparam int   NCMP           = NUM_COMPARE_DEF;
    localparam int   N_RANDOM       = 1600;
    localparam int   WATCHDOG_LIMIT = 1000;
    localparam int   MAX_PRINTED    = 50;
    localparam int   N_SCRIPT       = 28;
    localparam int   N_REGS         = 22;
    // operation code the block must treat as a no-op
    localparam op_t  OP_UNDEF       = 2'd3;

    typedef struct packed {
        data_t rd;
        logic  irq;
    } rsp_t;

    typedef struct {
        op_t     op;
        offset_t off;
        data_t   data;
        bit      typed;
        data_t   rd;
        logic    irq;
    } row_t;

    logic clk;
    logic rst_n;

    rpcc_req_if req_ch ();
    rpcc_rsp_if rsp_ch ();

    rtc_prescaled_counter_compare uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted peripheral state, reset values
    logic   rtc_run     = 1'b0;
    count_t cnt         = '0;
    presc_t presc       = '0;
    presc_t phase       = '0;
    count_t cc [NCMP]   = '{default: '0};
    logic   tick_ev     = 1'b0;
    logic   evt_ovf     = 1'b0;
    logic   evt_cmp [NCMP] = '{default: 1'b0};
    data_t  inten       = '0;
    data_t  evten       = '0;

    rsp_t   due_resp [$];
    bit     calm = 1'b0;
    int     errors = 0;
    int     n_resp = 0;
    int     n_reads = 0, n_writes = 0, n_ticks = 0, n_other = 0;
    int     n_incr = 0, n_wrap = 0, n_cmp_hit = 0, n_irq = 0;
    int     idle_cycles = 0;

    // Every offset that decodes to something, plus the first out-of-range bank slots
    offset_t reg_map [N_REGS] = '{
        OFF_START, OFF_STOP, OFF_CLEAR, OFF_TRIG_OVF, OFF_EVT_TICK, OFF_EVT_OVF,
        OFF_EVT_CMP, OFF_EVT_CMP + 12'd4, OFF_EVT_CMP + 12'd8, OFF_EVT_CMP + 12'd12,
        OFF_INTEN_SET, OFF_INTEN_CLR, OFF_EVTEN_SET, OFF_EVTEN_CLR,
        OFF_COUNTER, OFF_PRESC,
        OFF_CC, OFF_CC + 12'd4, OFF_CC + 12'd8, OFF_CC + 12'd12,
        OFF_EVT_CMP + 12'd16, OFF_CC + 12'd16
    };

    // Directed requests; typed rows carry a result readable straight off the spec
    row_t script [N_SCRIPT] = '{
        '{OP_READ,  OFF_COUNTER,          32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_READ,  OFF_PRESC,            32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_TICK,  OFF_START,            32'hFFFF_FFFF, 1'b1, 32'd0,         1'b0},
        '{OP_WRITE, OFF_INTEN_SET,        32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_INTEN_CLR,        32'd0,         1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_WRITE, OFF_INTEN_CLR,        32'hFFFF_FFFC, 1'b0, 32'd0,         1'b0},
        '{OP_WRITE, OFF_EVTEN_SET,        32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_EVTEN_CLR,        32'd0,         1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_WRITE, OFF_EVTEN_CLR,        32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_EVTEN_SET,        32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_WRITE, OFF_START,            32'd2,         1'b0, 32'd0,         1'b0},
        '{OP_TICK,  OFF_COUNTER,          32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_WRITE, OFF_CC + 12'd12,      32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_CC + 12'd12,      32'd0,         1'b1, 32'h00FF_FFFF, 1'b0},
        '{OP_WRITE, OFF_PRESC,            32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_PRESC,            32'd0,         1'b1, 32'h0000_0FFF, 1'b0},
        '{OP_WRITE, OFF_PRESC,            32'd0,         1'b0, 32'd0,         1'b0},
        '{OP_WRITE, OFF_TRIG_OVF,         TASK_TRIGGER,  1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_COUNTER,          32'd0,         1'b1, 32'h00FF_FFF0, 1'b0},
        '{OP_WRITE, OFF_START,            TASK_TRIGGER,  1'b0, 32'd0,         1'b0},
        '{OP_TICK,  OFF_START,            32'd0,         1'b0, 32'd0,         1'b0},
        '{OP_WRITE, OFF_CLEAR,            TASK_TRIGGER,  1'b0, 32'd0,         1'b0},
        '{OP_WRITE, OFF_COUNTER,          32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
        '{OP_READ,  OFF_COUNTER,          32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_READ,  OFF_EVT_CMP + 12'd1,  32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_READ,  OFF_CC + 12'd16,      32'd0,         1'b1, 32'd0,         1'b0},
        '{OP_UNDEF, 12'hFFF,              32'hFFFF_FFFF, 1'b1, 32'd0,         1'b0},
        '{OP_WRITE, OFF_STOP,             TASK_TRIGGER,  1'b0, 32'd0,         1'b0}
    };

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Index into a four-register bank, or -1 when outside it or unaligned
    function automatic int bank_of(input offset_t off, input offset_t base);
        offset_t d;
        if (off < base)
            return -1;
        d = off - base;
        if (d[1:0] != 2'b00 || int'(d >> 2) >= NCMP)
            return -1;
        return int'(d >> 2);
    endfunction

    // Apply one request to the predicted state and return its response
    function automatic rsp_t rtc_step(input op_t op, input offset_t off, input data_t d);
        rsp_t r;
        int   i;
        r = '0;
        case (op)
            OP_READ:
            begin
                case (off)
                    OFF_EVT_TICK:                 r.rd = data_t'(tick_ev);
                    OFF_EVT_OVF:                  r.rd = data_t'(evt_ovf);
                    OFF_INTEN_SET, OFF_INTEN_CLR: r.rd = inten;
                    OFF_EVTEN_SET, OFF_EVTEN_CLR: r.rd = evten;
                    OFF_COUNTER:                  r.rd = data_t'(cnt);
                    OFF_PRESC:                    r.rd = data_t'(presc);
                    default:
                    begin
                        i = bank_of(off, OFF_EVT_CMP);
                        if (i >= 0)
                            r.rd = data_t'(evt_cmp[i]);
                        i = bank_of(off, OFF_CC);
                        if (i >= 0)
                            r.rd = data_t'(cc[i]);
                    end
                endcase
            end
            OP_WRITE:
            begin
                case (off)
                    OFF_START:
                    begin
                        if (d == TASK_TRIGGER && !rtc_run)
                        begin
                            rtc_run = 1'b1;
                            phase   = presc;
                        end
                    end
                    OFF_STOP:      if (d == TASK_TRIGGER) rtc_run = 1'b0;
                    OFF_CLEAR:     if (d == TASK_TRIGGER) cnt = '0;
                    OFF_TRIG_OVF:  if (d == TASK_TRIGGER) cnt = OVF_PRESET;
                    OFF_EVT_TICK:  tick_ev = d[0];
                    OFF_EVT_OVF:   evt_ovf  = d[0];
                    OFF_INTEN_SET: inten = inten | d;
                    OFF_INTEN_CLR: inten = inten & ~d;
                    OFF_EVTEN_SET: evten = evten | d;
                    OFF_EVTEN_CLR: evten = evten & ~d;
                    OFF_PRESC:     presc = d[PRESC_W-1:0];
                    default:
                    begin
                        i = bank_of(off, OFF_EVT_CMP);
                        if (i >= 0)
                            evt_cmp[i] = d[0];
                        i = bank_of(off, OFF_CC);
                        if (i >= 0)
                            cc[i] = d[CNT_W-1:0];
                    end
                endcase
            end
            OP_TICK:
            begin
                if (rtc_run)
                begin
                    if (phase != '0)
                        phase = phase - 1'b1;
                    else
                    begin
                        // counter advances and latches its events
                        phase    = presc;
                        cnt      = cnt + 1'b1;
                        tick_ev  = 1'b1;
                        n_incr++;
                        if (cnt == '0)
                        begin
                            evt_ovf = 1'b1;
                            n_wrap++;
                        end
                        for (i = 0; i < NCMP; i++)
                            if (cc[i] == cnt)
                            begin
                                evt_cmp[i] = 1'b1;
                                n_cmp_hit++;
                            end
                        r.irq = (inten[INT_TICK_BIT] && tick_ev) ||
                                (inten[INT_OVF_BIT] && evt_ovf);
                        for (i = 0; i < NCMP; i++)
                            if (inten[INT_CMP_BASE + i] && evt_cmp[i])
                                r.irq = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic report(input string what, input data_t got, input data_t want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("MISMATCH response %0d %s: got %h, expected %h", n_resp, what, got, want);
    endtask

    // Send one request, then queue the response it should produce
    task automatic issue(input op_t op, input offset_t off, input data_t d,
                         input bit typed, input data_t t_rd, input logic t_irq);
        int   gap;
        rsp_t want;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.offset     <= off;
        req_ch.write_data <= d;
        do @(posedge clk); while (!req_ch.ready);
        want = rtc_step(op, off, d);
        if (typed)
        begin
            want.rd  = t_rd;
            want.irq = t_irq;
        end
        case (op)
            OP_READ:  n_reads++;
            OP_WRITE: n_writes++;
            OP_TICK:  n_ticks++;
            default:  n_other++;
        endcase
        due_resp.push_back(want);
    endtask

    // Response side: random back-pressure per response
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Response checker and watchdog
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_resp++;
            if (due_resp.size() == 0)
                report("unexpected response", rsp_ch.read_data, '0);
            else
            begin
                want = due_resp.pop_front();
                if (rsp_ch.read_data !== want.rd)
                    report("read_data", rsp_ch.read_data, want.rd);
                if (rsp_ch.irq_raise !== want.irq)
                    report("irq_raise", data_t'(rsp_ch.irq_raise), data_t'(want.irq));
                if (want.irq)
                    n_irq++;
            end
        end
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, due_resp.size());
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus
    initial
    begin
        op_t     op;
        offset_t off;
        data_t   d;
        int      sel;
        int      k;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_READ;
        req_ch.offset     <= '0;
        req_ch.write_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (script[r])
            issue(script[r].op, script[r].off, script[r].data,
                  script[r].typed, script[r].rd, script[r].irq);

        // random part: mostly ticks and meaningful accesses, some noise
        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = ((n / 150) % 3 == 1);
            op   = OP_WRITE;
            off  = '0;
            d    = $urandom;
            sel  = $urandom_range(0, 99);
            if (sel < 45)
                op = OP_TICK;
            else if (sel < 68)
            begin
                op  = OP_READ;
                off = reg_map[$urandom_range(0, N_REGS - 1)];
            end
            else if (sel < 94)
            begin
                case ($urandom_range(0, 8))
                    0, 1:
                    begin
                        // tasks; overflow trigger and start favoured to reach wraps
                        k = $urandom_range(0, 19);
                        off = (k < 8) ? OFF_START : (k < 11) ? OFF_STOP :
                              (k < 14) ? OFF_CLEAR : OFF_TRIG_OVF;
                        if ($urandom_range(0, 7) != 0)
                            d = TASK_TRIGGER;
                    end
                    2:
                    begin
                        k = $urandom_range(0, 5);
                        off = (k == 0) ? OFF_EVT_TICK : (k == 1) ? OFF_EVT_OVF :
                              OFF_EVT_CMP + offset_t'(4 * (k - 2));
                    end
                    3: off = $urandom_range(0, 1) ? OFF_INTEN_SET : OFF_INTEN_CLR;
                    4: off = $urandom_range(0, 1) ? OFF_EVTEN_SET : OFF_EVTEN_CLR;
                    5:
                    begin
                        // short prescale most of the time so the counter moves
                        off = OFF_PRESC;
                        if ($urandom_range(0, 24) != 0)
                            d[PRESC_W-1:0] = presc_t'($urandom_range(0, 3));
                    end
                    6, 7:
                    begin
                        // compare value just ahead of the count so matches occur
                        off = OFF_CC + offset_t'(4 * $urandom_range(0, NCMP - 1));
                        if ($urandom_range(0, 9) != 0)
                            d[CNT_W-1:0] = cnt + count_t'($urandom_range(0, 6));
                    end
                    default: off = OFF_COUNTER;
                endcase
            end
            else
            begin
                op  = op_t'($urandom_range(0, 3));
                off = offset_t'($urandom_range(0, 4095));
            end
            issue(op, off, d, 1'b0, '0, 1'b0);
        end
        req_ch.valid <= 1'b0;

        // drain, then let the pipeline settle
        while (due_resp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d requests: %0d reads, %0d writes, %0d ticks, %0d undefined",
                 n_reads + n_writes + n_ticks + n_other, n_reads, n_writes, n_ticks, n_other);
        $display("Counter advanced %0d times, wrapped %0d, %0d compare hits, %0d irq pulses",
                 n_incr, n_wrap, n_cmp_hit, n_irq);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> rtc_prescaled_counter_compare.f
+incdir+rtl
rtl/rpcc_pkg.sv
rtl/rpcc_req_if.sv
rtl/rpcc_rsp_if.sv
rtl/rtc_prescaled_counter_compare.sv
rtl/rpcc_checker.sv
verif/testbench.sv
